// ===== hw/rtl/strand_point_interval_lookup_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef STRAND_POINT_INTERVAL_LOOKUP_ASSERT_SVH
`define STRAND_POINT_INTERVAL_LOOKUP_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define SPIL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A signal holds its value in the cycle after the condition.
`define SPIL_ASSERT_HOLD(label, cond, sig, msg) \
  `SPIL_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

// ===== hw/rtl/spil_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spil_pkg;

  // Table geometry.
  localparam int TableDepth = 1024;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  // Field widths.
  localparam int CoordW = 32;
  localparam int GuideW = 6;
  localparam int OpW    = 2;
  localparam int ProbeW = CoordW + 2;

  // Stream payload widths, padded to whole bytes.
  localparam int InDataW  = 136;
  localparam int OutDataW = 40;

  // Constants of the probe point and the register reset.
  localparam logic [GuideW-1:0] GuideReset  = 6'd23;
  localparam logic [ProbeW-1:0] ProbeOffset = 34'd6;

  // Operation codes carried in tuser.
  localparam logic [OpW-1:0] OpLoad  = 2'd0;
  localparam logic [OpW-1:0] OpClear = 2'd1;
  localparam logic [OpW-1:0] OpQuery = 2'd2;

  // One stored table entry.
  typedef struct packed {
    logic [CoordW-1:0] id;
    logic [CoordW-1:0] hi;
    logic [CoordW-1:0] lo;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spil_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spil_ram #(
  parameter int Width = 96,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/strand_point_interval_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Interval lookup with a first-match scan. Load and clear transactions are
// applied as they are accepted, without a scan. A query transaction computes
// its probe point, then reads the table through its single read port one
// entry per cycle in load order and stops at the first entry that strictly
// contains the point, or after the last entry on a miss; an empty table is a
// miss without any read. The input is not ready during a scan, nor while a
// finished scan waits for the output register. The result waits in an output
// register, and a new item is taken while it waits. Loads beyond the table
// depth are dropped and raise the overflow flag. The table has no clearing
// pass: the fill count marks the valid entries.
module strand_point_interval_lookup
  import spil_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration: guide_length.
  input  wire logic                cfg_we_i,
  input  wire logic [GuideW-1:0]   cfg_wdata_i,
  // Input stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: region_start, region_end, region_id, position, reverse_strand, zero pad.
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // tuser: op.
  input  wire logic [OpW-1:0]      s_axis_tuser,
  // Output stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: found, match_id, table_overflowed, zero pad.
  output logic      [OutDataW-1:0] m_axis_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;

  logic [1:0]        state_q, state_d;
  logic [GuideW-1:0] guide_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic              chk_q, chk_d;
  logic              last_q, last_d;
  logic              empty_q, empty_d;
  logic [ProbeW-1:0] probe_q, probe_d;

  logic              out_valid_q;
  logic              out_found_q;
  logic [CoordW-1:0] out_id_q;
  logic              out_ovf_q;
  logic              out_load;

  logic              in_acc;
  logic [CoordW-1:0] in_start, in_end, in_id, in_pos;
  logic              in_rev;
  logic [OpW-1:0]    in_op;

  entry_t            wr_entry, rd_entry;
  logic              wr_en, rd_en;
  logic              table_full;
  logic              hit, done, out_free;
  logic signed [ProbeW-1:0] lo_s, hi_s, probe_s;

  // Input field unpacking.
  assign in_start = s_axis_tdata[31:0];
  assign in_end   = s_axis_tdata[63:32];
  assign in_id    = s_axis_tdata[95:64];
  assign in_pos   = s_axis_tdata[127:96];
  assign in_rev   = s_axis_tdata[128];
  assign in_op    = s_axis_tuser;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign table_full    = (count_q >= CntW'(TableDepth));

  // Guide length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guide_q <= GuideReset;
    end else if (cfg_we_i) begin
      guide_q <= cfg_wdata_i;
    end
  end

  // Table storage, written at the fill count.
  assign wr_en    = in_acc && (in_op == OpLoad) && !table_full;
  assign wr_entry = '{id: in_id, hi: in_end, lo: in_start};

  spil_ram #(
    .Width($bits(entry_t)),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  // Shared compare unit on the entry read in the previous cycle.
  assign lo_s    = $signed({2'b00, rd_entry.lo});
  assign hi_s    = $signed({2'b00, rd_entry.hi});
  assign probe_s = $signed(probe_q);
  assign hit     = chk_q && !empty_q && (lo_s < probe_s) && (probe_s < hi_s);
  assign done    = chk_q && (hit || last_q);
  assign out_free = !out_valid_q || m_axis_tready;

  // Scan sequencer.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    ptr_d    = ptr_q;
    chk_d    = chk_q;
    last_d   = last_q;
    empty_d  = empty_q;
    probe_d  = probe_q;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OpLoad: begin
              if (table_full) begin
                ovf_d = 1'b1;
              end else begin
                count_d = count_q + CntW'(1);
              end
            end
            OpClear: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            OpQuery: begin
              if (in_rev) begin
                probe_d = {2'b00, in_pos} + ProbeOffset;
              end else begin
                probe_d = {2'b00, in_pos} + {{(ProbeW-GuideW){1'b0}}, guide_q} - ProbeOffset;
              end
              ptr_d   = '0;
              empty_d = (count_q == '0);
              chk_d   = (count_q == '0);
              last_d  = 1'b1;
              state_d = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (done) begin
          if (out_free) begin
            out_load = 1'b1;
            chk_d    = 1'b0;
            state_d  = S_IDLE;
          end
        end else begin
          rd_en  = (ptr_q < count_q);
          chk_d  = rd_en;
          last_d = (ptr_q == (count_q - CntW'(1)));
          if (rd_en) begin
            ptr_d = ptr_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      ptr_q   <= '0;
      chk_q   <= 1'b0;
      last_q  <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      ptr_q   <= ptr_d;
      chk_q   <= chk_d;
      last_q  <= last_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= hit;
      out_id_q    <= hit ? rd_entry.id : '0;
      out_ovf_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-CoordW-2){1'b0}}, out_ovf_q, out_id_q, out_found_q};

endmodule

`default_nettype wire

// ===== hw/rtl/spil_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "strand_point_interval_lookup_assert.svh"

module spil_checker
  import spil_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [OpW-1:0]      s_axis_tuser,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  logic out_stall, query_acc, out_miss;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign query_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OpQuery);
  assign out_miss  = m_axis_tvalid && !m_axis_tdata[0];

  // A stalled result stays offered and unchanged.
  `SPIL_ASSERT(a_out_valid_hold, out_stall |=> m_axis_tvalid, "result dropped while stalled")
  `SPIL_ASSERT_HOLD(a_out_data_hold, out_stall, m_axis_tdata, "result changed while stalled")

  // A query starts a scan, so the input is busy in the next cycle.
  `SPIL_ASSERT(a_query_busy, query_acc |=> !s_axis_tready, "input ready right after a query")

  // A miss reports a zero id.
  `SPIL_ASSERT(a_miss_zero_id, out_miss |-> (m_axis_tdata[32:1] == 32'd0), "miss with nonzero id")

endmodule

bind strand_point_interval_lookup spil_checker u_spil_checker (.*);

`default_nettype wire

// ===== tb/sv/strand_point_interval_lookup_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the interval lookup,
// keeps its own copy of the interval table, and checks every result
// transaction against the oldest outstanding query.
module strand_point_interval_lookup_checker
  import spil_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [GuideW-1:0]   cfg_wdata_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [OpW-1:0]      s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  errors_o,
  output int                  pending_o
);

  // One query answer: found, match_id, table_overflowed.
  typedef struct packed {
    logic              found;
    logic [CoordW-1:0] match_id;
    logic              overflowed;
  } lookup_answer_t;

  entry_t            intervals [TableDepth];
  int unsigned       fill_count;
  logic              overflowed;
  logic [GuideW-1:0] guide_len;
  lookup_answer_t    pending_answers [$];

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    errors_o++;
  endtask

  // Place the probe point and scan the table for the first containing entry.
  function automatic lookup_answer_t find_interval(logic [CoordW-1:0] pos, logic rev);
    logic signed [ProbeW-1:0] point;
    lookup_answer_t           ans;
    point = {2'b00, pos} +
            (rev ? ProbeOffset : ({{(ProbeW-GuideW){1'b0}}, guide_len} - ProbeOffset));
    ans.found      = 1'b0;
    ans.match_id   = '0;
    ans.overflowed = overflowed;
    for (int i = 0; i < int'(fill_count); i++) begin
      if ($signed({2'b00, intervals[i].lo}) < point &&
          point < $signed({2'b00, intervals[i].hi})) begin
        ans.found    = 1'b1;
        ans.match_id = intervals[i].id;
        break;
      end
    end
    return ans;
  endfunction

  // Apply one accepted input transaction to the table copy.
  task automatic apply_item(logic [OpW-1:0] op, logic [InDataW-1:0] data);
    entry_t e;
    e.lo = data[31:0];
    e.hi = data[63:32];
    e.id = data[95:64];
    case (op)
      OpLoad: begin
        if (fill_count < TableDepth) begin
          intervals[fill_count] = e;
          fill_count++;
        end else begin
          overflowed = 1'b1;
        end
      end
      OpClear: begin
        fill_count = 0;
        overflowed = 1'b0;
      end
      OpQuery: begin
        pending_answers = {pending_answers, find_interval(data[127:96], data[128])};
      end
      default: begin
        // The unused operation code is ignored by the block.
      end
    endcase
  endtask

  // Compare one result transaction field by field.
  task automatic check_answer(logic [OutDataW-1:0] data);
    lookup_answer_t got;
    lookup_answer_t exp;
    got.found      = data[0];
    got.match_id   = data[32:1];
    got.overflowed = data[33];
    if (pending_answers.size() == 0) begin
      report_mismatch($sformatf("result with no query outstanding: found %0b id %0h",
                                got.found, got.match_id));
    end else begin
      exp = pending_answers.pop_front();
      if (got.found != exp.found)
        report_mismatch($sformatf("found: got %0b, expected %0b", got.found, exp.found));
      if (got.match_id != exp.match_id)
        report_mismatch($sformatf("match_id: got %0h, expected %0h",
                                  got.match_id, exp.match_id));
      if (got.overflowed != exp.overflowed)
        report_mismatch($sformatf("table_overflowed: got %0b, expected %0b",
                                  got.overflowed, exp.overflowed));
    end
  endtask

  // Sample both channels and the configuration port at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count = 0;
      overflowed = 1'b0;
      guide_len  = GuideReset;
      pending_answers.delete();
    end else begin
      if (cfg_we_i) guide_len = cfg_wdata_i;
      if (m_tvalid_i && m_tready_i) check_answer(m_tdata_i);
      if (s_tvalid_i && s_tready_i) apply_item(s_tuser_i, s_tdata_i);
    end
    pending_o = pending_answers.size();
  end

endmodule

// ===== tb/sv/strand_point_interval_lookup_tb.sv =====
`timescale 1ns / 1ps

module strand_point_interval_lookup_tb;
  import spil_pkg::*;

  // The fourth operation code has no meaning and is dropped by the block.
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int RandomItems = 135;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [GuideW-1:0]   cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int errors;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int loaded = 0;

  always #4 clk_i = ~clk_i;

  strand_point_interval_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  strand_point_interval_lookup_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Result side: random stalls, or a long hold-off while hold_left runs down.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one transaction after a random idle gap and wait until it is taken.
  task automatic send_item(logic [OpW-1:0] op, logic [31:0] lo, logic [31:0] hi,
                           logic [31:0] id, logic [31:0] pos, logic rev);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(InDataW-129){1'b0}}, rev, pos, id, hi, lo};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic load_interval(logic [31:0] lo, logic [31:0] hi, logic [31:0] id);
    send_item(OpLoad, lo, hi, id, $urandom, 1'($urandom_range(1)));
    loaded++;
  endtask

  task automatic query_point(logic [31:0] pos, logic rev);
    send_item(OpQuery, $urandom, $urandom, $urandom, pos, rev);
  endtask

  task automatic clear_table();
    send_item(OpClear, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
    loaded = 0;
  endtask

  // Stop offering, wait for every outstanding answer, then let the block settle.
  task automatic wait_idle(int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_guide(logic [GuideW-1:0] value);
    wait_idle(8);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Coordinates mostly fall in a small window so that queries hit often.
  function automatic logic [31:0] pick_coord();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(4095);
    if (sel < 80) return 32'hFFFF_F000 + $urandom_range(4095);
    return $urandom;
  endfunction

  // Mixed loads, queries, clears and unused operation codes on tables kept short.
  task automatic random_phase(int n_items);
    int          done;
    int          table_cap;
    int unsigned sel;
    logic [31:0] lo;
    done      = 0;
    table_cap = $urandom_range(4, 60);
    while (done < n_items) begin
      sel = $urandom_range(99);
      if (loaded >= table_cap) sel = 3;
      if (sel < 3 && loaded < table_cap) begin
        send_item(OpUnused, $urandom, $urandom, $urandom, $urandom,
                  1'($urandom_range(1)));
      end else begin
        if (sel < 8) begin
          clear_table();
          table_cap = $urandom_range(4, 60);
        end else if (sel < 50) begin
          lo = pick_coord();
          if ($urandom_range(99) < 85)
            load_interval(lo, lo + $urandom_range(1, 400), $urandom);
          else
            load_interval(lo, pick_coord(), $urandom);
        end else begin
          query_point(pick_coord(), 1'($urandom_range(1)));
        end
        done++;
      end
    end
  endtask

  initial begin
    #8_000_000;
    $display("strand_point_interval_lookup_tb failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks with the reset guide length: forward point is pos + 17.
    query_point(32'd0, 1'b0);
    load_interval(32'd100, 32'd200, 32'h1234_5678);
    load_interval(32'd50, 32'd300, 32'hFFFF_FFFF);
    load_interval(32'h0, 32'hFFFF_FFFF, 32'h0);
    load_interval(32'hFFFF_FFFF, 32'h0, 32'h8000_0001);
    query_point(32'd83, 1'b0);
    query_point(32'd84, 1'b0);
    query_point(32'd94, 1'b1);
    query_point(32'd194, 1'b1);
    query_point(32'd0, 1'b1);
    query_point(32'hFFFF_FFFF, 1'b0);
    query_point(32'hFFFF_FFF8, 1'b1);
    query_point(32'hFFFF_FFF9, 1'b1);
    send_item(OpUnused, $urandom, $urandom, $urandom, $urandom, 1'b1);
    clear_table();
    query_point(32'd150, 1'b1);

    // Guide lengths below the offset push the probe point negative.
    set_guide(6'd0);
    load_interval(32'd0, 32'd10, 32'hA5A5_5A5A);
    query_point(32'd0, 1'b0);
    query_point(32'd6, 1'b0);
    query_point(32'd7, 1'b0);
    set_guide(6'd1);
    query_point(32'd4, 1'b0);
    query_point(32'd5, 1'b0);

    // Random traffic under each idling pattern.
    set_guide(6'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(RandomItems);
    set_guide(6'd63);
    send_idle_pct  = 76;
    recv_stall_pct = 0;
    random_phase(RandomItems);
    set_guide(6'd5);
    send_idle_pct  = 0;
    recv_stall_pct = 76;
    random_phase(RandomItems);
    set_guide(6'($urandom_range(63)));
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    random_phase(RandomItems);

    // Hold the result side off while queries keep coming, so the input stalls.
    set_guide(6'd23);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    clear_table();
    for (int k = 0; k < 4; k++)
      load_interval(k * 100, k * 100 + 80, $urandom);
    wait_idle(8);
    hold_left = 400;
    for (int k = 0; k < 12; k++)
      query_point($urandom_range(420), 1'($urandom_range(1)));

    wait_idle(TableDepth + 8);
    if (errors == 0 && pending == 0)
      $display("strand_point_interval_lookup_tb passed");
    else
      $display("strand_point_interval_lookup_tb failed");
    $finish;
  end

endmodule

// ===== strand_point_interval_lookup.f =====
+incdir+hw/rtl
hw/rtl/spil_pkg.sv
hw/rtl/spil_ram.sv
hw/rtl/strand_point_interval_lookup.sv
hw/rtl/spil_checker.sv
tb/sv/strand_point_interval_lookup_checker.sv
tb/sv/strand_point_interval_lookup_tb.sv
